[design/assert_macros.svh]
// Assertion helpers for the RTL files.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock, idle during reset.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define BBA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/bba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Constants, status codes and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ARENA_ORDER  = 16;
  localparam int MIN_ORDER    = 5;
  localparam int HEADER_BYTES = 24;

  localparam int ORD_W   = 5;
  localparam int ADDR_W  = 16;
  localparam int SIZE_W  = 32;
  localparam int USED_W  = ARENA_ORDER + 1;
  localparam int IDX_W   = ARENA_ORDER - MIN_ORDER;
  localparam int NODE_AW = IDX_W + 1;
  localparam int NODE_CNT = 1 << NODE_AW;
  localparam int SLOT_CNT = 1 << IDX_W;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Clamp the arena register into the supported order range.
  function automatic logic [ORD_W-1:0] eff_order(input logic [ORD_W-1:0] a);
    logic [ORD_W-1:0] r;
    r = a;
    if (a < ORD_W'(MIN_ORDER)) r = ORD_W'(MIN_ORDER);
    if (a > ORD_W'(ARENA_ORDER)) r = ORD_W'(ARENA_ORDER);
    return r;
  endfunction

  // Flat tree position of node (ord, idx); orders are stored top down.
  function automatic logic [NODE_AW-1:0] node_at(input logic [ORD_W-1:0] ord,
                                                 input logic [IDX_W-1:0] idx);
    logic [NODE_AW:0] base;
    base = ((NODE_AW+1)'(1) << (ORD_W'(ARENA_ORDER) - ord)) - (NODE_AW+1)'(1);
    return NODE_AW'(base) + {1'b0, idx};
  endfunction

endpackage

[design/bba_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_in_if
// Request channel: operation, requested size and address to release.
// ----------------------------------------------------------------------------
interface bba_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [bba_pkg::SIZE_W-1:0] req_size;
  logic [bba_pkg::ADDR_W-1:0] free_addr;

  modport source (output valid, func, req_size, free_addr, input ready);
  modport sink   (input valid, func, req_size, free_addr, output ready);
endinterface

[design/bba_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_out_if
// Result channel: returned offset, status and bytes in use.
// ----------------------------------------------------------------------------
interface bba_out_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::ADDR_W-1:0] alloc_addr;
  logic [1:0]                 status;
  logic [bba_pkg::USED_W-1:0] used_bytes;

  modport source (output valid, alloc_addr, status, used_bytes, input ready);
  modport sink   (input valid, alloc_addr, status, used_bytes, output ready);
endinterface

[design/bba_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_cfg_if
// Configuration write channel for the arena order register.
// ----------------------------------------------------------------------------
interface bba_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bba_pkg::ORD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[design/bba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic [$clog2(D)-1:0] addr,
  input  logic                 we,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/buddy_block_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator: a sequencer walks a free-node tree memory and a
// per-slot order table, one node probe or update per step.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | func, req_size, free_addr
//  out_ch  | out | valid/ready       | alloc_addr, status, used_bytes
//  cfg_ch  | in  | valid/ready (=1)  | data (arena order)
//
// Reset and every config write start a sweep over the whole free-node memory that clears both
// memories and marks the whole arena free; no item is taken during it.
// An allocate steps up the sizes (S_SIZE), probes tree nodes in turn (S_SRCH_RD,
// S_SRCH_CHK) and splits (S_SPLIT); a free checks the table, then merges level by level.
// Worst case is a minimum-size allocate that probes all 4095 nodes.
// One item at a time: in_ch.ready is low while an item is at work.
// A finished result waits in the output register; a stalled out_ch holds it.
`include "assert_macros.svh"

module buddy_block_allocator_unit (
  input  logic     clk,
  input  logic     rst_n,
  bba_in_if.sink   in_ch,
  bba_out_if.source out_ch,
  bba_cfg_if.sink  cfg_ch
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SIZE, S_SRCH_RD, S_SRCH_CHK, S_SPLIT,
    S_FREE, S_FCHK, S_MRG_RD, S_MRG_CHK, S_MRG_SET, S_DONE
  } state_t;

  state_t                          state_r;
  logic [bba_pkg::ORD_W-1:0]       arena_r;
  logic [bba_pkg::NODE_AW-1:0]     clr_r;
  logic [bba_pkg::SIZE_W:0]        total_r;
  logic [bba_pkg::ADDR_W-1:0]      fa_r;
  logic [bba_pkg::ORD_W-1:0]       ord_r;
  logic [bba_pkg::ORD_W-1:0]       need_r;
  logic [bba_pkg::IDX_W-1:0]       idx_r;
  logic [bba_pkg::USED_W-1:0]      used_r;
  logic [bba_pkg::ADDR_W-1:0]      res_addr_r;
  logic [1:0]                      res_st_r;
  logic                            out_valid_r;
  logic [bba_pkg::ADDR_W-1:0]      out_addr_r;
  logic [1:0]                      out_st_r;
  logic [bba_pkg::USED_W-1:0]      out_used_r;

  logic [bba_pkg::ORD_W-1:0]       aeff;
  logic [bba_pkg::NODE_AW-1:0]     root;
  logic [bba_pkg::ADDR_W-1:0]      fstart;
  logic [bba_pkg::ADDR_W-1:0]      astart;
  logic [bba_pkg::IDX_W-1:0]       last_idx;
  logic                            cfg_wr;

  logic [bba_pkg::NODE_AW-1:0]     fm_addr;
  logic                            fm_we;
  logic                            fm_wd;
  logic                            fm_rd;
  logic [bba_pkg::IDX_W-1:0]       at_addr;
  logic                            at_we;
  logic [bba_pkg::ORD_W-1:0]       at_wd;
  logic [bba_pkg::ORD_W-1:0]       at_rd;

  assign aeff     = bba_pkg::eff_order(arena_r);
  assign root     = bba_pkg::node_at(aeff, '0);
  assign fstart   = fa_r - bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
  // block start of the allocation found: idx at the needed order
  assign astart   = bba_pkg::ADDR_W'({{(bba_pkg::ADDR_W-bba_pkg::IDX_W){1'b0}}, idx_r}
                    << need_r);
  assign last_idx = bba_pkg::IDX_W'(((bba_pkg::IDX_W+1)'(1) << (aeff - ord_r))
                    - (bba_pkg::IDX_W+1)'(1));
  assign cfg_wr   = cfg_ch.valid && cfg_ch.ready;

  assign cfg_ch.ready     = 1'b1;
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.alloc_addr = out_addr_r;
  assign out_ch.status    = out_st_r;
  assign out_ch.used_bytes = out_used_r;

  // Memory port steering per sequencer step.
  always_comb begin
    fm_addr = bba_pkg::node_at(ord_r, idx_r);
    fm_we   = 1'b0;
    fm_wd   = 1'b0;
    at_addr = fstart[bba_pkg::ADDR_W-1:bba_pkg::MIN_ORDER];
    at_we   = 1'b0;
    at_wd   = '0;
    case (state_r)
      S_CLEAR: begin
        fm_addr = clr_r;
        fm_we   = 1'b1;
        fm_wd   = (clr_r == root);
        at_addr = clr_r[bba_pkg::IDX_W-1:0];
        at_we   = 1'b1;
      end
      S_SRCH_CHK: begin
        // claim the free node just probed
        fm_we = fm_rd;
      end
      S_SPLIT: begin
        if (ord_r > need_r) begin
          // upper half of each split goes free
          fm_addr = bba_pkg::node_at(ord_r - 1'b1, {idx_r[bba_pkg::IDX_W-2:0], 1'b1});
          fm_we   = 1'b1;
          fm_wd   = 1'b1;
        end else begin
          at_addr = astart[bba_pkg::ADDR_W-1:bba_pkg::MIN_ORDER];
          at_we   = 1'b1;
          at_wd   = need_r;
        end
      end
      S_FCHK: begin
        at_we = (at_rd >= bba_pkg::ORD_W'(bba_pkg::MIN_ORDER)) && (at_rd <= aeff);
      end
      S_MRG_RD: begin
        fm_addr = bba_pkg::node_at(ord_r, idx_r ^ bba_pkg::IDX_W'(1));
      end
      S_MRG_CHK: begin
        // buddy free: absorb it
        fm_addr = bba_pkg::node_at(ord_r, idx_r ^ bba_pkg::IDX_W'(1));
        fm_we   = fm_rd;
      end
      S_MRG_SET: begin
        fm_we = 1'b1;
        fm_wd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  bba_ram #(.W(1), .D(bba_pkg::NODE_CNT)) u_free_map (
    .clk   (clk),
    .addr  (fm_addr),
    .we    (fm_we),
    .wdata (fm_wd),
    .rdata (fm_rd)
  );

  bba_ram #(.W(bba_pkg::ORD_W), .D(bba_pkg::SLOT_CNT)) u_order_tab (
    .clk   (clk),
    .addr  (at_addr),
    .we    (at_we),
    .wdata (at_wd),
    .rdata (at_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      arena_r     <= bba_pkg::ORD_W'(bba_pkg::ARENA_ORDER);
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            total_r <= {1'b0, in_ch.req_size}
                       + (bba_pkg::SIZE_W+1)'(bba_pkg::HEADER_BYTES);
            fa_r    <= in_ch.free_addr;
            ord_r   <= bba_pkg::ORD_W'(bba_pkg::MIN_ORDER);
            // only a successful allocate sets a returned offset
            res_addr_r <= '0;
            state_r <= (in_ch.func == bba_pkg::FUNC_ALLOC) ? S_SIZE : S_FREE;
          end
        end
        S_SIZE: begin
          // smallest order whose block exceeds size plus header
          if (total_r < ((bba_pkg::SIZE_W+1)'(1) << ord_r)) begin
            need_r  <= ord_r;
            idx_r   <= '0;
            state_r <= S_SRCH_RD;
          end else if (ord_r >= aeff) begin
            res_st_r <= bba_pkg::ST_NO_SPACE;
            state_r  <= S_DONE;
          end else begin
            ord_r <= ord_r + 1'b1;
          end
        end
        S_SRCH_RD: begin
          state_r <= S_SRCH_CHK;
        end
        S_SRCH_CHK: begin
          if (fm_rd) begin
            state_r <= S_SPLIT;
          end else if (idx_r == last_idx) begin
            if (ord_r >= aeff) begin
              res_st_r <= bba_pkg::ST_NO_SPACE;
              state_r  <= S_DONE;
            end else begin
              ord_r   <= ord_r + 1'b1;
              idx_r   <= '0;
              state_r <= S_SRCH_RD;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SRCH_RD;
          end
        end
        S_SPLIT: begin
          if (ord_r > need_r) begin
            ord_r <= ord_r - 1'b1;
            idx_r <= {idx_r[bba_pkg::IDX_W-2:0], 1'b0};
          end else begin
            used_r     <= used_r + (bba_pkg::USED_W'(1) << need_r);
            res_addr_r <= astart + bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
            res_st_r   <= bba_pkg::ST_OK;
            state_r    <= S_DONE;
          end
        end
        S_FREE: begin
          // reject before the table read: below header, misaligned, outside
          if ((fa_r < bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES))
              || (fstart[bba_pkg::MIN_ORDER-1:0] != '0)
              || ({1'b0, fstart} >= ((bba_pkg::ADDR_W+1)'(1) << aeff))) begin
            res_st_r <= bba_pkg::ST_BAD_FREE;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_FCHK;
          end
        end
        S_FCHK: begin
          if ((at_rd >= bba_pkg::ORD_W'(bba_pkg::MIN_ORDER)) && (at_rd <= aeff)) begin
            used_r  <= used_r - (bba_pkg::USED_W'(1) << at_rd);
            ord_r   <= at_rd;
            idx_r   <= bba_pkg::IDX_W'(fstart >> at_rd);
            state_r <= S_MRG_RD;
          end else begin
            res_st_r <= bba_pkg::ST_BAD_FREE;
            state_r  <= S_DONE;
          end
        end
        S_MRG_RD: begin
          state_r <= (ord_r >= aeff) ? S_MRG_SET : S_MRG_CHK;
        end
        S_MRG_CHK: begin
          if (fm_rd) begin
            idx_r   <= idx_r >> 1;
            ord_r   <= ord_r + 1'b1;
            state_r <= S_MRG_RD;
          end else begin
            state_r <= S_MRG_SET;
          end
        end
        S_MRG_SET: begin
          res_st_r <= bba_pkg::ST_OK;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_addr_r  <= res_addr_r;
            out_st_r    <= res_st_r;
            out_used_r  <= used_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_wr) begin
        // new arena: drop everything and rebuild the maps
        arena_r <= cfg_ch.data;
        used_r  <= '0;
        clr_r   <= '0;
        state_r <= S_CLEAR;
      end
    end
  end

  `BBA_ASSERT(a_used_fits, used_r <= (bba_pkg::USED_W'(1) << aeff), "used bytes exceed arena")
  `BBA_NEVER(a_status_code, out_ch.valid && out_ch.status == 2'd3, "undefined status code")
  `BBA_ASSERT(a_cfg_clears, cfg_wr |=> (used_r == '0 && state_r == S_CLEAR),
              "config did not reset maps")
  `BBA_ASSERT(a_out_hold, out_valid_r && !out_ch.ready
              |=> out_valid_r && $stable({out_addr_r, out_st_r, out_used_r}),
              "result changed while stalled")

endmodule

[tb/bba_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_tb_if
// Testbench-side channel bundles are the design interfaces; nothing extra
// is needed here beyond a shared type for one predicted result.
// ----------------------------------------------------------------------------
package bba_tb_pkg;
  import bba_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] alloc_addr;
    logic [1:0]        status;
    logic [USED_W-1:0] used_bytes;
  } bba_result_t;
endpackage

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buddy block allocator. A behavioral allocator
// predicts every result; directed tests hit size limits, full arenas, bad
// frees and arena order extremes, then random alloc/free traffic runs with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import bba_pkg::*;
  import bba_tb_pkg::*;

  localparam int WATCHDOG = 50000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bba_in_if  in_ch();
  bba_out_if out_ch();
  bba_cfg_if cfg_ch();

  buddy_block_allocator_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state: tree of free flags, order per minimum slot, bytes used.
  logic              node_free [NODE_CNT];
  logic [ORD_W-1:0]  slot_order [SLOT_CNT];
  logic [USED_W-1:0] bytes_used;
  logic [ORD_W-1:0]  arena_reg;

  bba_result_t pending_results[$];
  logic [ADDR_W-1:0] live_addrs[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet = 0;   // no idling in the final stretch

  function automatic int arena_bits();
    int a;
    a = arena_reg;
    if (a < MIN_ORDER) a = MIN_ORDER;
    if (a > ARENA_ORDER) a = ARENA_ORDER;
    return a;
  endfunction

  function automatic int tree_pos(int ord, int idx);
    return ((1 << (ARENA_ORDER - ord)) - 1) + idx;
  endfunction

  function automatic void clear_arena();
    foreach (node_free[i]) node_free[i] = 1'b0;
    foreach (slot_order[i]) slot_order[i] = '0;
    bytes_used = '0;
    node_free[tree_pos(arena_bits(), 0)] = 1'b1;
  endfunction

  // Compute the result of one item and update the predicted allocator state.
  function automatic bba_result_t predict_alloc_free(logic fn, logic [31:0] sz,
                                                     logic [15:0] fa);
    bba_result_t r;
    int a, need, ord, idx, start, slot;
    longint total;
    bit found;
    a = arena_bits();
    r.alloc_addr = '0;
    r.status = ST_OK;
    if (fn == FUNC_ALLOC) begin
      total = longint'(sz) + HEADER_BYTES;
      need = 0;
      while (total > 1) begin
        total = total >> 1;
        need++;
      end
      need++;
      if (need < MIN_ORDER) need = MIN_ORDER;
      found = 0;
      idx = 0;
      ord = need;
      if (need <= a) begin
        for (ord = need; ord <= a && !found; ord++) begin
          for (idx = 0; idx < (1 << (a - ord)); idx++) begin
            if (node_free[tree_pos(ord, idx)]) begin
              found = 1;
              break;
            end
          end
        end
      end
      if (!found) begin
        r.status = ST_NO_SPACE;
      end else begin
        ord--;
        node_free[tree_pos(ord, idx)] = 1'b0;
        while (ord > need) begin
          ord--;
          idx = idx << 1;
          node_free[tree_pos(ord, idx + 1)] = 1'b1;
        end
        start = idx << need;
        slot_order[start >> MIN_ORDER] = ORD_W'(need);
        bytes_used += USED_W'(1 << need);
        r.alloc_addr = ADDR_W'(start + HEADER_BYTES);
      end
    end else begin
      start = int'(fa) - HEADER_BYTES;
      if (fa < HEADER_BYTES || start[MIN_ORDER-1:0] != 0 || start >= (1 << a)
          || slot_order[start >> MIN_ORDER] < MIN_ORDER
          || slot_order[start >> MIN_ORDER] > a) begin
        r.status = ST_BAD_FREE;
      end else begin
        slot = start >> MIN_ORDER;
        ord = slot_order[slot];
        slot_order[slot] = '0;
        bytes_used -= USED_W'(1 << ord);
        idx = start >> ord;
        while (ord < a && node_free[tree_pos(ord, idx ^ 1)]) begin
          node_free[tree_pos(ord, idx ^ 1)] = 1'b0;
          idx = idx >> 1;
          ord++;
        end
        node_free[tree_pos(ord, idx)] = 1'b1;
      end
    end
    r.used_bytes = bytes_used;
    return r;
  endfunction

  // Random hold-off before sending, sometimes.
  task automatic maybe_gap();
    int n;
    if (!quiet && $urandom_range(3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) @(posedge clk);
    end
  endtask

  // Send one item, predict it at acceptance.
  task automatic send_item(logic fn, logic [31:0] sz, logic [15:0] fa);
    bba_result_t r;
    maybe_gap();
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.req_size <= sz;
    in_ch.free_addr <= fa;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    r = predict_alloc_free(fn, sz, fa);
    pending_results.push_back(r);
    if (fn == FUNC_ALLOC && r.status == ST_OK) live_addrs.push_back(r.alloc_addr);
    // let valid drop; the unit is busy with this item meanwhile
    @(posedge clk);
  endtask

  task automatic alloc_bytes(logic [31:0] sz);
    send_item(FUNC_ALLOC, sz, ADDR_W'($urandom));
  endtask

  task automatic free_addr(logic [15:0] fa);
    int k;
    send_item(FUNC_FREE, SIZE_W'($urandom), fa);
    for (k = 0; k < live_addrs.size(); k++) begin
      if (live_addrs[k] == fa) begin
        live_addrs.delete(k);
        break;
      end
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Write the arena order while idle and reset the predicted state to match the cleared maps.
  task automatic write_arena(logic [ORD_W-1:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    arena_reg = v;
    clear_arena();
    live_addrs.delete();
  endtask

  task automatic free_all();
    while (live_addrs.size() != 0) free_addr(live_addrs[0]);
  endtask

  task automatic test_sizes();
    alloc_bytes(32'd0);
    alloc_bytes(32'd7);
    alloc_bytes(32'd8);
    alloc_bytes(32'hFFFF_FFFF);
    alloc_bytes(32'd65536);
    alloc_bytes(32'd32767 - HEADER_BYTES);
    alloc_bytes(32'd1000);
    free_all();
    alloc_bytes(32'd65535 - HEADER_BYTES);   // whole arena
    alloc_bytes(32'd1);                      // arena full
    free_all();
  endtask

  task automatic test_bad_free();
    alloc_bytes(32'd100);
    free_addr(16'd0);
    free_addr(16'd23);
    free_addr(16'd25);
    free_addr(16'd24 + 16'd64);    // aligned but never allocated
    free_addr(16'hFFFF);
    free_all();
    free_addr(16'd24);             // double free
  endtask

  task automatic test_small_arena();
    write_arena(5'd0);             // saturates to the minimum order
    alloc_bytes(32'd7);
    alloc_bytes(32'd0);
    free_addr(16'd24);
    write_arena(5'd31);            // saturates to the maximum order
    alloc_bytes(32'd40000);
    write_arena(5'd6);
    alloc_bytes(32'd0);
    alloc_bytes(32'd0);
    alloc_bytes(32'd0);
    free_addr(16'd56);
    free_all();
  endtask

  task automatic random_traffic(int items, logic [ORD_W-1:0] ord);
    int i, sel;
    logic [31:0] sz;
    write_arena(ord);
    for (i = 0; i < items; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        case ($urandom_range(3))
          0: sz = $urandom_range(0, 40);
          1: sz = $urandom_range(0, 600);
          2: sz = $urandom_range(0, 1 << arena_bits());
          default: sz = $urandom;
        endcase
        alloc_bytes(sz);
      end else if (sel < 88 && live_addrs.size() != 0) begin
        free_addr(live_addrs[$urandom_range(live_addrs.size() - 1)]);
      end else begin
        free_addr(ADDR_W'($urandom));
      end
    end
  endtask

  // Result side: random stalls, compare each item with the oldest prediction.
  initial begin
    bba_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item");
        end else begin
          want = pending_results.pop_front();
          if (out_ch.alloc_addr !== want.alloc_addr || out_ch.status !== want.status
              || out_ch.used_bytes !== want.used_bytes) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp addr %0d st %0d used %0d, got %0d %0d %0d",
                       want.alloc_addr, want.status, want.used_bytes,
                       out_ch.alloc_addr, out_ch.status, out_ch.used_bytes);
          end
        end
      end
      out_ch.ready <= quiet ? 1'b1 : ($urandom_range(3) != 0);
    end
  end

  // Watchdog: count cycles with no handshake on any channel.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.func <= 1'b0;
    in_ch.req_size <= '0;
    in_ch.free_addr <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    arena_reg = 5'd16;
    clear_arena();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_sizes();
    test_bad_free();
    test_small_arena();
    random_traffic(300, 5'd16);
    random_traffic(250, 5'd8);
    random_traffic(200, 5'd12);
    random_traffic(100, 5'd5);
    quiet = 1;
    random_traffic(250, 5'd10);
    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
